### design/star_to_image_plane_projection_unit_defines.svh
// Assertion macros shared by the star projection unit
`ifndef STAR_TO_IMAGE_PLANE_PROJECTION_UNIT_DEFINES_SVH
`define STAR_TO_IMAGE_PLANE_PROJECTION_UNIT_DEFINES_SVH
`ifndef SYNTH
`define STP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define STP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define STP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define STP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### design/stp_pkg.sv
// Shared types, constants and rounding functions of the star projection unit
`default_nettype none
package stp_pkg;

   localparam int ANGLE_W     = 16;
   localparam int QUARTER_TURN = 16384;
   localparam int CSR_W       = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int VEC_W       = 16;
   localparam int MAT_W       = 18;
   localparam int PROD_W      = MAT_W + VEC_W;
   localparam int DEN_W       = 36;
   localparam int NUM_W       = 54;
   localparam int DIVIDEND_W  = 55;
   localparam int REM_W       = 60;
   localparam int DIV_QW      = 24;
   localparam int DIV_LAT     = DIV_QW + 1;
   localparam int OUT_W       = 24;
   localparam int SINE_LAT    = 7;
   localparam int FRONT_LAT   = SINE_LAT + 1;
   localparam int ATT_LAT     = SINE_LAT + 2;
   localparam int BACK_LAT    = 4 + DIV_LAT;
   localparam int QUEUE_DEPTH = 16;

   localparam logic signed [31:0] SIN_C1 = 32'sd1686629713;
   localparam logic signed [31:0] SIN_C3 = 32'sd693598670;
   localparam logic signed [31:0] SIN_C5 = 32'sd85569306;
   localparam logic signed [31:0] SIN_C7 = 32'sd5026994;
   localparam logic signed [31:0] SIN_C9 = 32'sd172272;

   localparam logic [OUT_W-1:0] OUT_MAX = 24'h7FFFFF;
   localparam logic [OUT_W-1:0] OUT_MIN = 24'h800000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAM_ASCENSION,
      CSR_CAM_DECLINATION,
      CSR_CAM_ROLL,
      CSR_FOCAL_LENGTH
   } csr_index_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [VEC_W-1:0] z;
   } star_vec_type;

   typedef struct packed {
      logic signed [MAT_W-1:0] a1;
      logic signed [MAT_W-1:0] a2;
      logic signed [MAT_W-1:0] a3;
      logic signed [MAT_W-1:0] b1;
      logic signed [MAT_W-1:0] b2;
      logic signed [MAT_W-1:0] b3;
      logic signed [MAT_W-1:0] c1;
      logic signed [MAT_W-1:0] c2;
      logic signed [MAT_W-1:0] c3;
   } matrix_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic zero_den;
      logic neg_x;
      logic nz_x;
      logic neg_y;
      logic nz_y;
   } side_type;

   // Q30 to Q15, nearest, ties away from zero
   function automatic logic signed [20:0] rnd15(input logic signed [35:0] p);
      logic signed [35:0] a;
      if (p >= 0) begin
         a = (p + 36'sd16384) >>> 15;
      end else begin
         a = -((-p + 36'sd16384) >>> 15);
      end
      return 21'(a);
   endfunction

   function automatic logic signed [VEC_W-1:0] mulq(input logic signed [VEC_W-1:0] a,
                                                     input logic signed [VEC_W-1:0] b);
      logic signed [35:0] p;
      p = 36'(a) * 36'(b);
      return VEC_W'(rnd15(p));
   endfunction

endpackage
`default_nettype wire

### design/stp_if.sv
// Request and response channel interfaces of the star projection unit
`default_nettype none
interface stp_req_if;
   logic                valid;
   logic                ready;
   logic [15:0]         star_ascension;
   logic signed [15:0]  star_declination;

   modport source (output valid, output star_ascension, output star_declination, input ready);
   modport sink   (input valid, input star_ascension, input star_declination, output ready);
endinterface

interface stp_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [23:0]  spot_x;
   logic signed [23:0]  spot_y;
   logic                saturated;

   modport source (output valid, output spot_x, output spot_y, output saturated, input ready);
   modport sink   (input valid, input spot_x, input spot_y, input saturated, output ready);
endinterface
`default_nettype wire

### design/star_to_image_plane_projection_unit.sv
// Top level of the star-tracker image plane projection unit
`default_nettype none
// Projects catalogue stars onto the star-tracker image plane.
// req_if carries one star (right ascension, declination as turn fractions);
// rsp_if returns spot_x, spot_y (Q19.4 pixels) and the saturated flag, one
// response per request, in request order.
// csr_* writes camera ascension, declination, roll and focal length; write
// only while no request is in flight.
// Throughput: one request per cycle while req_if.ready is high. The front
// computes the star vector in an eight-stage pipeline (seven-stage sine plus
// the vector product) and pushes it into a QUEUE_DEPTH-entry queue; the back
// rotates, scales and divides over 29 stages plus an output register.
// Most of the delay to rsp_if.valid comes from the 24-step pipelined
// divider. After reset or any csr write, req_if.ready stays low while
// the rotation matrix is recomputed. A stalled receiver freezes the back
// pipe; the queue keeps absorbing the front, and req_if.ready drops once
// the queue's credits run out. Reset clears all control state and the csr
// registers, but not the datapath registers.
module star_to_image_plane_projection_unit #(
   parameter int QUEUE_DEPTH = stp_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   stp_req_if.sink                           req_if,
   stp_rsp_if.source                         rsp_if,
   input  logic                              csr_write_enable,
   input  logic [stp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [stp_pkg::CSR_W-1:0]         csr_write_data
);

`include "star_to_image_plane_projection_unit_defines.svh"

   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

   logic [15:0]               cam_ascension_ff;
   logic signed [15:0]        cam_declination_ff;
   logic [15:0]               cam_roll_ff;
   logic [15:0]               focal_length_ff;
   logic                      busy;
   logic                      accept;
   logic                      front_push;
   logic                      pop;
   stp_pkg::star_vec_type     front_vec;
   stp_pkg::star_vec_type     queue_vec;
   stp_pkg::queue_status_type queue_status;
   stp_pkg::matrix_type       matrix;
   logic [OCC_W-1:0]          occ_ff;
   logic [OCC_W-1:0]          occ_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cam_ascension_ff   <= '0;
         cam_declination_ff <= '0;
         cam_roll_ff        <= '0;
         focal_length_ff    <= '0;
      end else if (csr_write_enable) begin
         case (stp_pkg::csr_index_type'(csr_index))
            stp_pkg::CSR_CAM_ASCENSION:   cam_ascension_ff   <= csr_write_data;
            stp_pkg::CSR_CAM_DECLINATION: cam_declination_ff <= csr_write_data;
            stp_pkg::CSR_CAM_ROLL:        cam_roll_ff        <= csr_write_data;
            stp_pkg::CSR_FOCAL_LENGTH:    focal_length_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // occupancy counts requests in the front pipe plus entries in the queue,
   // so a push never finds the queue full
   assign accept       = req_if.valid && req_if.ready;
   assign req_if.ready = !busy && (occ_ff < OCC_W'(QUEUE_DEPTH));

   always_comb begin
      occ_in = occ_ff;
      if (accept && !pop) begin
         occ_in = occ_ff + 1'b1;
      end else if (pop && !accept) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   stp_attitude u_attitude (
      .clock           (clock),
      .reset           (reset),
      .cfg_write       (csr_write_enable),
      .cam_ascension   (cam_ascension_ff),
      .cam_declination (cam_declination_ff),
      .cam_roll        (cam_roll_ff),
      .matrix          (matrix),
      .busy            (busy)
   );

   stp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .star_ascension   (req_if.star_ascension),
      .star_declination (req_if.star_declination),
      .push             (front_push),
      .vec              (front_vec)
   );

   stp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_vec),
      .pop       (pop),
      .pop_data  (queue_vec),
      .status    (queue_status)
   );

   stp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .vec          (queue_vec),
      .status       (queue_status),
      .pop          (pop),
      .matrix       (matrix),
      .focal_length (focal_length_ff),
      .rsp_if       (rsp_if)
   );

   // drop ready for the cycle after a register write
   `STP_ASSERT_NEXT(a_csr_blocks_request, clock, reset, csr_write_enable, !req_if.ready, "request taken while attitude settles")
   // front pushes always find room in the queue
   `STP_ASSERT_IMPLY(a_push_room, clock, reset, front_push, !queue_status.full, "queue overflow on push")
   // occupancy never runs past the queue depth
   `STP_ASSERT_IMPLY(a_occ_bound, clock, reset, 1'b1, occ_ff <= OCC_W'(QUEUE_DEPTH), "occupancy beyond queue depth")

endmodule
`default_nettype wire

### design/stp_sine.sv
// Seven-stage pipelined sine of a 16-bit turn fraction, Q1.15 result
`default_nettype none
module stp_sine (
   input  logic                                clock,
   input  logic [stp_pkg::ANGLE_W-1:0]         angle,
   output logic signed [stp_pkg::VEC_W-1:0]    value
);

   // one Horner step: c - (z2 * p) >> 30
   function automatic logic signed [31:0] horner(input logic [30:0] z2,
                                                 input logic signed [31:0] p,
                                                 input logic signed [31:0] c);
      logic signed [63:0] prod;
      prod = 64'($signed({1'b0, z2})) * 64'(p);
      return c - 32'(prod >>> 30);
   endfunction

   logic [14:0]        rr_in;
   logic [29:0]        sq_in;
   logic [30:0]        z2_in;
   logic signed [46:0] sp_in;
   logic signed [32:0] t_in;
   logic signed [15:0] mag_in;

   logic               neg1_ff, neg2_ff, neg3_ff, neg4_ff, neg5_ff, neg6_ff;
   logic [14:0]        rr1_ff, rr2_ff, rr3_ff, rr4_ff, rr5_ff;
   logic [30:0]        z21_ff, z22_ff, z23_ff, z24_ff;
   logic signed [31:0] p7_ff, p5_ff, p3_ff, p1_ff, s6_ff;
   logic signed [15:0] value_ff;

   always_comb begin
      // fold the quadrant onto the rising quarter wave
      rr_in  = angle[14] ? (15'(stp_pkg::QUARTER_TURN) - {1'b0, angle[13:0]})
                         : {1'b0, angle[13:0]};
      sq_in  = 30'(rr_in) * 30'(rr_in);
      z2_in  = {sq_in[28:0], 2'b00};
      sp_in  = 47'($signed({1'b0, rr5_ff})) * 47'(p1_ff);
      t_in   = (33'(s6_ff) + 33'sd16384) >>> 15;
      mag_in = (t_in > 33'sd32767) ? 16'sd32767 : 16'(t_in);
   end

   always_ff @(posedge clock) begin
      neg1_ff  <= angle[15];
      rr1_ff   <= rr_in;
      z21_ff   <= z2_in;

      neg2_ff  <= neg1_ff;
      rr2_ff   <= rr1_ff;
      z22_ff   <= z21_ff;
      p7_ff    <= horner(z21_ff, stp_pkg::SIN_C9, stp_pkg::SIN_C7);

      neg3_ff  <= neg2_ff;
      rr3_ff   <= rr2_ff;
      z23_ff   <= z22_ff;
      p5_ff    <= horner(z22_ff, p7_ff, stp_pkg::SIN_C5);

      neg4_ff  <= neg3_ff;
      rr4_ff   <= rr3_ff;
      z24_ff   <= z23_ff;
      p3_ff    <= horner(z23_ff, p5_ff, stp_pkg::SIN_C3);

      neg5_ff  <= neg4_ff;
      rr5_ff   <= rr4_ff;
      p1_ff    <= horner(z24_ff, p3_ff, stp_pkg::SIN_C1);

      neg6_ff  <= neg5_ff;
      s6_ff    <= 32'(sp_in >>> 14);

      value_ff <= neg6_ff ? -mag_in : mag_in;
   end

   assign value = value_ff;

endmodule
`default_nettype wire

### design/stp_front.sv
// Front part: star unit vector from right ascension and declination
`default_nettype none
module stp_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [15:0]                       star_ascension,
   input  logic signed [15:0]                star_declination,
   output logic                              push,
   output stp_pkg::star_vec_type             vec
);

   logic [15:0]                       de_bits;
   logic [15:0]                       ra_cos_angle;
   logic [15:0]                       de_cos_angle;
   logic signed [stp_pkg::VEC_W-1:0]  cos_ra, sin_ra, cos_de, sin_de;
   logic [stp_pkg::FRONT_LAT-1:0]     valid_ff;
   stp_pkg::star_vec_type             vec_ff;

   assign de_bits      = star_declination;
   assign ra_cos_angle = 16'(star_ascension + 16'(stp_pkg::QUARTER_TURN));
   assign de_cos_angle = 16'(de_bits + 16'(stp_pkg::QUARTER_TURN));

   stp_sine u_cos_ra (.clock(clock), .angle(ra_cos_angle),   .value(cos_ra));
   stp_sine u_sin_ra (.clock(clock), .angle(star_ascension), .value(sin_ra));
   stp_sine u_cos_de (.clock(clock), .angle(de_cos_angle),   .value(cos_de));
   stp_sine u_sin_de (.clock(clock), .angle(de_bits),        .value(sin_de));

   always_ff @(posedge clock) begin
      vec_ff.x <= stp_pkg::mulq(cos_ra, cos_de);
      vec_ff.y <= stp_pkg::mulq(sin_ra, cos_de);
      vec_ff.z <= sin_de;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[stp_pkg::FRONT_LAT-2:0], accept};
      end
   end

   assign push = valid_ff[stp_pkg::FRONT_LAT-1];
   assign vec  = vec_ff;

endmodule
`default_nettype wire

### design/stp_attitude.sv
// Camera rotation matrix from boresight ascension, declination and roll
`default_nettype none
module stp_attitude (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cfg_write,
   input  logic [15:0]              cam_ascension,
   input  logic signed [15:0]       cam_declination,
   input  logic [15:0]              cam_roll,
   output stp_pkg::matrix_type      matrix,
   output logic                     busy
);

   localparam int CW = $clog2(stp_pkg::ATT_LAT + 1);

   logic [15:0]        dec_bits, asc_cos_angle, dec_cos_angle, roll_cos_angle;
   logic signed [15:0] ca, sa, cd, sd, ct, st;
   logic signed [15:0] casd_ff, sasd_ff, ca_ff, sa_ff, ct_ff, st_ff;
   logic signed [stp_pkg::MAT_W-1:0] a3_ff, b3_ff, c1_ff, c2_ff, c3_ff;
   stp_pkg::matrix_type matrix_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;

   assign dec_bits       = cam_declination;
   assign asc_cos_angle  = 16'(cam_ascension + 16'(stp_pkg::QUARTER_TURN));
   assign dec_cos_angle  = 16'(dec_bits + 16'(stp_pkg::QUARTER_TURN));
   assign roll_cos_angle = 16'(cam_roll + 16'(stp_pkg::QUARTER_TURN));

   stp_sine u_ca (.clock(clock), .angle(asc_cos_angle),  .value(ca));
   stp_sine u_sa (.clock(clock), .angle(cam_ascension),  .value(sa));
   stp_sine u_cd (.clock(clock), .angle(dec_cos_angle),  .value(cd));
   stp_sine u_sd (.clock(clock), .angle(dec_bits),       .value(sd));
   stp_sine u_ct (.clock(clock), .angle(roll_cos_angle), .value(ct));
   stp_sine u_st (.clock(clock), .angle(cam_roll),       .value(st));

   // first step: two-factor terms and the rounded ca*sd, sa*sd
   always_ff @(posedge clock) begin
      casd_ff <= stp_pkg::mulq(ca, sd);
      sasd_ff <= stp_pkg::mulq(sa, sd);
      a3_ff   <= stp_pkg::MAT_W'(stp_pkg::rnd15(-(36'(ca) * 36'(cd))));
      b3_ff   <= stp_pkg::MAT_W'(stp_pkg::rnd15(-(36'(sa) * 36'(cd))));
      c1_ff   <= stp_pkg::MAT_W'(stp_pkg::rnd15(36'(ca) * 36'(st)));
      c2_ff   <= stp_pkg::MAT_W'(stp_pkg::rnd15(36'(ca) * 36'(ct)));
      c3_ff   <= -stp_pkg::MAT_W'(sd);
      ca_ff   <= ca;
      sa_ff   <= sa;
      ct_ff   <= ct;
      st_ff   <= st;
   end

   // second step: the three-factor terms
   always_ff @(posedge clock) begin
      matrix_ff.a1 <= stp_pkg::MAT_W'(stp_pkg::rnd15(
                         36'(sa_ff) * 36'(ct_ff) - 36'(casd_ff) * 36'(st_ff)));
      matrix_ff.a2 <= stp_pkg::MAT_W'(stp_pkg::rnd15(
                         -(36'(sa_ff) * 36'(st_ff)) - 36'(casd_ff) * 36'(ct_ff)));
      matrix_ff.b1 <= stp_pkg::MAT_W'(stp_pkg::rnd15(
                         -(36'(ca_ff) * 36'(ct_ff)) - 36'(sasd_ff) * 36'(st_ff)));
      matrix_ff.b2 <= stp_pkg::MAT_W'(stp_pkg::rnd15(
                         36'(ca_ff) * 36'(st_ff) - 36'(sasd_ff) * 36'(ct_ff)));
      matrix_ff.a3 <= a3_ff;
      matrix_ff.b3 <= b3_ff;
      matrix_ff.c1 <= c1_ff;
      matrix_ff.c2 <= c2_ff;
      matrix_ff.c3 <= c3_ff;
   end

   // hold busy until a changed attitude has reached the matrix
   always_comb begin
      if (cfg_write) begin
         count_in = CW'(stp_pkg::ATT_LAT);
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CW'(stp_pkg::ATT_LAT);
      end else begin
         count_ff <= count_in;
      end
   end

   assign busy   = (count_ff != '0);
   assign matrix = matrix_ff;

endmodule
`default_nettype wire

### design/stp_queue.sv
// Small FIFO between the front and back parts
`default_nettype none
module stp_queue #(
   parameter int DEPTH = stp_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  stp_pkg::star_vec_type       push_data,
   input  logic                        pop,
   output stp_pkg::star_vec_type       pop_data,
   output stp_pkg::queue_status_type   status
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   stp_pkg::star_vec_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule
`default_nettype wire

### design/stp_div.sv
// Pipelined restoring divider: 24-bit quotient with overflow detect
`default_nettype none
module stp_div (
   input  logic                               clock,
   input  logic                               en,
   input  logic [stp_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [stp_pkg::DEN_W-1:0]          divisor,
   output logic [stp_pkg::DIV_QW-1:0]         quot,
   output logic                               ovf
);

   localparam int QW = stp_pkg::DIV_QW;
   localparam int RW = stp_pkg::REM_W;

   logic [RW-1:0]                rem_ff [QW+1];
   logic [stp_pkg::DEN_W-1:0]    den_ff [QW+1];
   logic [QW-1:0]                q_ff   [QW+1];
   logic                         ovf_ff [QW+1];
   logic [RW:0]                  limit_in;

   // quotient would need more than the available bits
   assign limit_in = (RW + 1)'(divisor) << QW;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= RW'(dividend);
         den_ff[0] <= divisor;
         q_ff[0]   <= '0;
         ovf_ff[0] <= ((RW + 1)'(dividend) >= limit_in);
      end
   end

   for (genvar j = 1; j <= QW; j++) begin : g_bit
      localparam int K = QW - j;
      logic [RW-1:0] sub;
      assign sub = RW'(den_ff[j-1]) << K;
      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[j] <= den_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
            if (rem_ff[j-1] >= sub) begin
               rem_ff[j] <= rem_ff[j-1] - sub;
               q_ff[j]   <= q_ff[j-1] | (QW'(1) << K);
            end else begin
               rem_ff[j] <= rem_ff[j-1];
               q_ff[j]   <= q_ff[j-1];
            end
         end
      end
   end

   assign quot = q_ff[QW];
   assign ovf  = ovf_ff[QW];

endmodule
`default_nettype wire

### design/stp_back.sv
// Back part: rotation, focal scaling, division and saturation of each star
`default_nettype none
module stp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  stp_pkg::star_vec_type       vec,
   input  stp_pkg::queue_status_type   status,
   output logic                        pop,
   input  stp_pkg::matrix_type         matrix,
   input  logic [15:0]                 focal_length,
   stp_rsp_if.source                   rsp_if
);

   localparam int PW = stp_pkg::PROD_W;
   localparam int DW = stp_pkg::DEN_W;
   localparam int NW = stp_pkg::NUM_W;
   localparam int XW = stp_pkg::DIVIDEND_W;
   localparam int QW = stp_pkg::DIV_QW;
   localparam int OW = stp_pkg::OUT_W;
   localparam int BL = stp_pkg::BACK_LAT;

   // sat flag and value of one coordinate
   function automatic logic [OW:0] finish(input logic zero, input logic neg, input logic nz,
                                          input logic ovf, input logic [QW-1:0] q);
      logic [OW:0] r;
      if (zero) begin
         r = nz ? {1'b1, (neg ? stp_pkg::OUT_MIN : stp_pkg::OUT_MAX)} : {1'b1, OW'(0)};
      end else if (ovf) begin
         r = {1'b1, (neg ? stp_pkg::OUT_MIN : stp_pkg::OUT_MAX)};
      end else if (neg) begin
         r = (q > stp_pkg::OUT_MIN) ? {1'b1, stp_pkg::OUT_MIN}
                                    : {1'b0, OW'(-$signed({1'b0, q}))};
      end else begin
         r = q[QW-1] ? {1'b1, stp_pkg::OUT_MAX} : {1'b0, OW'(q)};
      end
      return r;
   endfunction

   logic                    adv;
   logic [BL-1:0]           valid_ff;
   logic signed [PW-1:0]    prod_ff [9];
   logic signed [DW-1:0]    nx_ff, ny_ff, den_ff, den3_ff;
   logic signed [NW-1:0]    num_x_ff, num_y_ff;
   logic [NW-1:0]           an_x_in, an_y_in;
   logic [DW-1:0]           ad_in, ad_ff;
   logic [XW-1:0]           dvd_x_ff, dvd_y_ff;
   stp_pkg::side_type       side_in;
   stp_pkg::side_type       side_ff [stp_pkg::DIV_LAT+1];
   logic [QW-1:0]           qx, qy;
   logic                    ovf_x, ovf_y;
   logic [OW:0]             res_x_in, res_y_in;
   logic                    rsp_valid_ff;
   logic [OW-1:0]           spot_x_ff, spot_y_ff;
   logic                    saturated_ff;

   // advance the whole back pipe unless a finished result is stuck
   assign adv = !rsp_valid_ff || rsp_if.ready;
   assign pop = adv && !status.empty;

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff[0] <= PW'(matrix.a1) * PW'(vec.x);
         prod_ff[1] <= PW'(matrix.b1) * PW'(vec.y);
         prod_ff[2] <= PW'(matrix.c1) * PW'(vec.z);
         prod_ff[3] <= PW'(matrix.a2) * PW'(vec.x);
         prod_ff[4] <= PW'(matrix.b2) * PW'(vec.y);
         prod_ff[5] <= PW'(matrix.c2) * PW'(vec.z);
         prod_ff[6] <= PW'(matrix.a3) * PW'(vec.x);
         prod_ff[7] <= PW'(matrix.b3) * PW'(vec.y);
         prod_ff[8] <= PW'(matrix.c3) * PW'(vec.z);

         nx_ff  <= DW'(prod_ff[0]) + DW'(prod_ff[1]) + DW'(prod_ff[2]);
         ny_ff  <= DW'(prod_ff[3]) + DW'(prod_ff[4]) + DW'(prod_ff[5]);
         den_ff <= DW'(prod_ff[6]) + DW'(prod_ff[7]) + DW'(prod_ff[8]);

         num_x_ff <= NW'($signed({1'b0, focal_length})) * NW'(nx_ff);
         num_y_ff <= NW'($signed({1'b0, focal_length})) * NW'(ny_ff);
         den3_ff  <= den_ff;

         // rounding half of the divisor goes onto the dividend
         dvd_x_ff <= XW'(an_x_in) + XW'(ad_in >> 1);
         dvd_y_ff <= XW'(an_y_in) + XW'(ad_in >> 1);
         ad_ff    <= ad_in;
         side_ff[0] <= side_in;
      end
   end

   always_comb begin
      an_x_in          = num_x_ff[NW-1] ? NW'(-num_x_ff) : NW'(num_x_ff);
      an_y_in          = num_y_ff[NW-1] ? NW'(-num_y_ff) : NW'(num_y_ff);
      ad_in            = den3_ff[DW-1] ? DW'(-den3_ff) : DW'(den3_ff);
      side_in.zero_den = (den3_ff == '0);
      side_in.neg_x    = num_x_ff[NW-1] ^ den3_ff[DW-1];
      side_in.nz_x     = (num_x_ff != '0);
      side_in.neg_y    = num_y_ff[NW-1] ^ den3_ff[DW-1];
      side_in.nz_y     = (num_y_ff != '0);
   end

   stp_div u_div_x (.clock(clock), .en(adv), .dividend(dvd_x_ff), .divisor(ad_ff),
                    .quot(qx), .ovf(ovf_x));
   stp_div u_div_y (.clock(clock), .en(adv), .dividend(dvd_y_ff), .divisor(ad_ff),
                    .quot(qy), .ovf(ovf_y));

   for (genvar k = 1; k <= stp_pkg::DIV_LAT; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign res_x_in = finish(side_ff[stp_pkg::DIV_LAT].zero_den, side_ff[stp_pkg::DIV_LAT].neg_x,
                            side_ff[stp_pkg::DIV_LAT].nz_x, ovf_x, qx);
   assign res_y_in = finish(side_ff[stp_pkg::DIV_LAT].zero_den, side_ff[stp_pkg::DIV_LAT].neg_y,
                            side_ff[stp_pkg::DIV_LAT].nz_y, ovf_y, qy);

   always_ff @(posedge clock) begin
      if (adv) begin
         spot_x_ff    <= res_x_in[OW-1:0];
         spot_y_ff    <= res_y_in[OW-1:0];
         saturated_ff <= res_x_in[OW] | res_y_in[OW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff     <= {valid_ff[BL-2:0], !status.empty};
         rsp_valid_ff <= valid_ff[BL-1];
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.spot_x    = spot_x_ff;
   assign rsp_if.spot_y    = spot_y_ff;
   assign rsp_if.saturated = saturated_ff;

endmodule
`default_nettype wire
